[sv/vcc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcc_pkg
// Shared constants, types and neighbor tables for the voxel cliff cost block.
// ----------------------------------------------------------------------------
package vcc_pkg;

   localparam int MAX_WIDTH  = 64;
   localparam int MAX_HEIGHT = 32;
   localparam int MAX_DEPTH  = 64;

   localparam int X_W      = 6;
   localparam int Y_W      = 5;
   localparam int Z_W      = 6;
   localparam int ADDR_W   = X_W + Z_W;
   localparam int WORD_W   = MAX_HEIGHT;
   localparam int COST_W   = 8;
   localparam int WIDTH_W  = 7;
   localparam int HEIGHT_W = 6;
   localparam int DEPTH_W  = 7;
   localparam int CLIMB_W  = 5;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   localparam int NB_COUNT = 8;
   localparam int NB_W     = 4;

   localparam logic [COST_W-1:0] COST_OUTSIDE = 8'd2;
   localparam logic [COST_W-1:0] COST_CLIFF   = 8'd4;
   localparam logic [COST_W-1:0] COST_LIMIT   = 8'd254;

   localparam logic [WIDTH_W-1:0]  WIDTH_LIMIT  = 7'd64;
   localparam logic [HEIGHT_W-1:0] HEIGHT_LIMIT = 6'd32;
   localparam logic [DEPTH_W-1:0]  DEPTH_LIMIT  = 7'd64;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_WIDTH  = 2'd0,
      CSR_GRID_HEIGHT = 2'd1,
      CSR_GRID_DEPTH  = 2'd2,
      CSR_MAX_CLIMB   = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WR_MOD,
      ST_OWN,
      ST_NB,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [WORD_W-1:0] wr_data;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

   // Neighbor offsets as 2-bit two's complement (-1, 0, +1).
   function automatic logic [1:0] nb_dx(input logic [2:0] k);
      logic [1:0] d;
      case (k)
         3'd0, 3'd3, 3'd5: d = 2'b11;
         3'd1, 3'd6:       d = 2'b00;
         default:          d = 2'b01;
      endcase
      return d;
   endfunction

   function automatic logic [1:0] nb_dz(input logic [2:0] k);
      logic [1:0] d;
      case (k)
         3'd0, 3'd1, 3'd2: d = 2'b11;
         3'd3, 3'd4:       d = 2'b00;
         default:          d = 2'b01;
      endcase
      return d;
   endfunction

endpackage

[sv/vcc_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcc_req_if / vcc_rsp_if
// Valid/ready channels for request beats and cost response beats.
// ----------------------------------------------------------------------------
interface vcc_req_if
   import vcc_pkg::*;
   ();
   logic           valid;
   logic           ready;
   logic           func;
   logic [X_W-1:0] pos_x;
   logic [Y_W-1:0] pos_y;
   logic [Z_W-1:0] pos_z;
   logic           walkable;

   modport source (output valid, func, pos_x, pos_y, pos_z, walkable, input ready);
   modport sink   (input valid, func, pos_x, pos_y, pos_z, walkable, output ready);
endinterface

interface vcc_rsp_if
   import vcc_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [COST_W-1:0] cost;
   logic              coord_error;

   modport source (output valid, cost, coord_error, input ready);
   modport sink   (input valid, cost, coord_error, output ready);
endinterface

[sv/vcc_column_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcc_column_mem
// Column store: one word per (x, z) position, bit y is the voxel at height y.
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module vcc_column_mem
   import vcc_pkg::*;
(
   input  logic              clock,
   input  mem_req_type       mem_req,
   output logic [WORD_W-1:0] rd_data_ff
);

   logic [WORD_W-1:0] column_store [MAX_WIDTH*MAX_DEPTH];

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         column_store[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= column_store[mem_req.rd_addr];
   end

endmodule

[sv/voxel_cliff_cost.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_cliff_cost
// Walkable-voxel grid with cliff-aware traversal cost queries.
// ----------------------------------------------------------------------------
// Write beats (func 0) set or clear one voxel bit with a read-modify-write of
// its column word; a write outside the grid is dropped. A query beat (func 1)
// reads its own column, then streams the eight neighbor columns through the
// single memory read port while one adder folds each neighbor's cost into the
// total. A query on an unwalkable voxel or outside the grid skips the neighbor
// scan. One beat is in work at a time; the response sits in an output register
// so the next request is taken while it waits, and a second finished query
// holds the block until that register drains. The column store has no reset:
// every voxel a query may touch must be written first.
module voxel_cliff_cost
   import vcc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   vcc_req_if.sink               req_if,
   vcc_rsp_if.source             rsp_if
);

   // configuration
   logic [WIDTH_W-1:0]  grid_width_ff;
   logic [HEIGHT_W-1:0] grid_height_ff;
   logic [DEPTH_W-1:0]  grid_depth_ff;
   logic [CLIMB_W-1:0]  max_climb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= WIDTH_LIMIT;
         grid_height_ff <= HEIGHT_LIMIT;
         grid_depth_ff  <= DEPTH_LIMIT;
         max_climb_ff   <= 5'd2;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_GRID_WIDTH:  grid_width_ff  <= csr_write_data[WIDTH_W-1:0];
            CSR_GRID_HEIGHT: grid_height_ff <= csr_write_data[HEIGHT_W-1:0];
            CSR_GRID_DEPTH:  grid_depth_ff  <= csr_write_data[DEPTH_W-1:0];
            CSR_MAX_CLIMB:   max_climb_ff   <= csr_write_data[CLIMB_W-1:0];
            default: ;
         endcase
      end
   end

   logic [WIDTH_W-1:0]  w_lim;
   logic [HEIGHT_W-1:0] h_lim;
   logic [DEPTH_W-1:0]  d_lim;

   assign w_lim = (grid_width_ff  > WIDTH_LIMIT)  ? WIDTH_LIMIT  : grid_width_ff;
   assign h_lim = (grid_height_ff > HEIGHT_LIMIT) ? HEIGHT_LIMIT : grid_height_ff;
   assign d_lim = (grid_depth_ff  > DEPTH_LIMIT)  ? DEPTH_LIMIT  : grid_depth_ff;

   // registers
   state_type         state_ff, state_in;
   logic [X_W-1:0]    pos_x_ff, pos_x_in;
   logic [Y_W-1:0]    pos_y_ff, pos_y_in;
   logic [Z_W-1:0]    pos_z_ff, pos_z_in;
   logic              walkable_ff, walkable_in;
   logic [COST_W-1:0] cost_ff, cost_in;
   logic              err_ff, err_in;
   logic [WORD_W-1:0] mask_ff, mask_in;
   logic [NB_W-1:0]   nb_cnt_ff, nb_cnt_in;
   logic              nb_out_ff, nb_out_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [COST_W-1:0] rsp_cost_ff, rsp_cost_in;
   logic              rsp_err_ff, rsp_err_in;

   mem_req_type       mem_req;
   logic [WORD_W-1:0] rd_data_ff;

   vcc_column_mem u_mem (
      .clock      (clock),
      .mem_req    (mem_req),
      .rd_data_ff (rd_data_ff)
   );

   // request inside test
   logic req_inside;
   assign req_inside = ({1'b0, req_if.pos_x} < w_lim) &&
                       ({1'b0, req_if.pos_y} < h_lim) &&
                       ({1'b0, req_if.pos_z} < d_lim);

   // support window for the queried height
   logic [6:0] y7, mc_lim, win_lo, win_hi_raw, win_cap, win_hi;
   logic [WORD_W-1:0] win_mask;

   assign y7         = {2'b00, pos_y_ff};
   assign mc_lim     = {2'b00, max_climb_ff} + 7'd2;
   assign win_lo     = (y7 >= mc_lim) ? (y7 - mc_lim) : 7'd0;
   assign win_hi_raw = y7 + {2'b00, max_climb_ff};
   assign win_cap    = {1'b0, h_lim} - 7'd1;
   assign win_hi     = (win_hi_raw > win_cap) ? win_cap : win_hi_raw;

   always_comb begin
      for (int i = 0; i < WORD_W; i++) begin
         win_mask[i] = (7'(i) >= win_lo) && (7'(i) <= win_hi);
      end
   end

   // neighbor address generation
   logic [2:0]     nb_idx;
   logic [7:0]     nb_x, nb_z;
   logic           nb_outside;
   logic [1:0]     dx, dz;

   assign nb_idx = nb_cnt_ff[2:0];
   assign dx     = nb_dx(nb_idx);
   assign dz     = nb_dz(nb_idx);
   assign nb_x   = {2'b00, pos_x_ff} + {{6{dx[1]}}, dx};
   assign nb_z   = {2'b00, pos_z_ff} + {{6{dz[1]}}, dz};
   assign nb_outside = nb_x[7] || nb_z[7] ||
                       (nb_x[WIDTH_W-1:0] >= w_lim) || (nb_z[DEPTH_W-1:0] >= d_lim);

   // shared cost adder
   logic [COST_W-1:0] addend;
   logic [COST_W:0]   cost_sum;
   logic [COST_W-1:0] cost_sat;

   assign addend   = nb_out_ff ? COST_OUTSIDE :
                     (((rd_data_ff & mask_ff) == '0) ? COST_CLIFF : '0);
   assign cost_sum = {1'b0, cost_ff} + {1'b0, addend};
   assign cost_sat = (cost_sum > {1'b0, COST_LIMIT}) ? COST_LIMIT : cost_sum[COST_W-1:0];

   logic              own_bit;
   logic [WORD_W-1:0] y_bit;
   assign own_bit = rd_data_ff[pos_y_ff];
   assign y_bit   = WORD_W'(1) << pos_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_x_ff    <= pos_x_in;
      pos_y_ff    <= pos_y_in;
      pos_z_ff    <= pos_z_in;
      walkable_ff <= walkable_in;
      cost_ff     <= cost_in;
      err_ff      <= err_in;
      mask_ff     <= mask_in;
      nb_cnt_ff   <= nb_cnt_in;
      nb_out_ff   <= nb_out_in;
      rsp_cost_ff <= rsp_cost_in;
      rsp_err_ff  <= rsp_err_in;
   end

   always_comb begin
      state_in     = state_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      pos_z_in     = pos_z_ff;
      walkable_in  = walkable_ff;
      cost_in      = cost_ff;
      err_in       = err_ff;
      mask_in      = mask_ff;
      nb_cnt_in    = nb_cnt_ff;
      nb_out_in    = nb_out_ff;
      rsp_cost_in  = rsp_cost_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      req_if.ready = 1'b0;
      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = {pos_z_ff, pos_x_ff};
      mem_req.wr_data = walkable_ff ? (rd_data_ff | y_bit) : (rd_data_ff & ~y_bit);
      mem_req.rd_addr = {pos_z_ff, pos_x_ff};

      case (state_ff)
         ST_IDLE: begin
            req_if.ready    = 1'b1;
            mem_req.rd_addr = {req_if.pos_z, req_if.pos_x};
            if (req_if.valid) begin
               pos_x_in    = req_if.pos_x;
               pos_y_in    = req_if.pos_y;
               pos_z_in    = req_if.pos_z;
               walkable_in = req_if.walkable;
               if (req_if.func == FUNC_WRITE) begin
                  // drop writes outside the grid
                  if (req_inside) begin
                     state_in = ST_WR_MOD;
                  end
               end else if (req_inside) begin
                  err_in   = 1'b0;
                  state_in = ST_OWN;
               end else begin
                  cost_in  = '0;
                  err_in   = 1'b1;
                  state_in = ST_DONE;
               end
            end
         end
         ST_WR_MOD: begin
            mem_req.wr_en = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_OWN: begin
            if (own_bit) begin
               cost_in   = 8'd1;
               mask_in   = win_mask;
               nb_cnt_in = '0;
               state_in  = ST_NB;
            end else begin
               cost_in  = '0;
               state_in = ST_DONE;
            end
         end
         ST_NB: begin
            // fold the column read last cycle, issue the next neighbor
            if (nb_cnt_ff != '0) begin
               cost_in = cost_sat;
            end
            if (nb_cnt_ff == NB_W'(NB_COUNT)) begin
               state_in = ST_DONE;
            end else begin
               mem_req.rd_addr = {nb_z[Z_W-1:0], nb_x[X_W-1:0]};
               nb_out_in       = nb_outside;
               nb_cnt_in       = nb_cnt_ff + NB_W'(1);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_cost_in  = cost_ff;
               rsp_err_in   = err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.cost        = rsp_cost_ff;
   assign rsp_if.coord_error = rsp_err_ff;

endmodule

[sv/vcc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcc_checker
// Port-level checks on the voxel cliff cost block, bound to the top level.
// ----------------------------------------------------------------------------
module vcc_checker
   import vcc_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              req_func,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [COST_W-1:0] rsp_cost,
   input logic              rsp_coord_error
);

   // a stalled response beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cost) && $stable(rsp_coord_error))
      else $error("response beat changed while stalled");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_coord_error |-> rsp_cost == '0)
      else $error("coordinate error with nonzero cost");

   // costs are 1 plus multiples of 2, or zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cost != '0 |-> rsp_cost[0] && rsp_cost <= COST_LIMIT)
      else $error("malformed cost");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_func == FUNC_QUERY |=> !req_ready)
      else $error("request taken while a query is in work");

endmodule

bind voxel_cliff_cost vcc_checker u_vcc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_if.valid),
   .req_ready       (req_if.ready),
   .req_func        (req_if.func),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_cost        (rsp_if.cost),
   .rsp_coord_error (rsp_if.coord_error)
);

[test/voxel_cliff_cost_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_cliff_cost_tb
// Self-checking bench for the voxel cliff cost block. Each phase programs the
// grid size and climb height while the block is idle. It then loads every not
// yet written voxel of the grid and runs a mix of writes and queries. Request and
// response beats are throttled at random. A cost predictor tracks the
// occupancy grid and checks each response beat against the oldest expected
// result.
// ----------------------------------------------------------------------------
module voxel_cliff_cost_tb;
   import vcc_pkg::*;

   localparam int RESET_CYCLES  = 11;
   localparam int SETTLE_CYCLES = 30;
   localparam int HOLD_CYCLES   = 400;
   localparam int TIMEOUT_NS    = 4_000_000;
   localparam int QUERY_PCT     = 60;
   localparam int WIDE_PCT      = 15;
   localparam int PRINT_LIMIT   = 200;
   localparam int IDLE_NONE     = 0;
   localparam int IDLE_HEAVY    = 48;
   localparam int IDLE_MIXED    = 28;

   typedef struct packed {
      logic           func;
      logic [X_W-1:0] x;
      logic [Y_W-1:0] y;
      logic [Z_W-1:0] z;
      logic           walkable;
   } voxel_beat_type;

   typedef struct packed {
      logic [COST_W-1:0] cost;
      logic              coord_error;
   } cost_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   vcc_req_if req_ch();
   vcc_rsp_if rsp_ch();

   voxel_cliff_cost DUT (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .req_if         (req_ch),
      .rsp_if         (rsp_ch)
   );

   voxel_beat_type  beat_pending_q[$];
   cost_result_type cost_expect_q[$];

   // Predictor copy of the grid and registers.
   logic [WORD_W-1:0]   column_bits [MAX_DEPTH][MAX_WIDTH];
   logic [WIDTH_W-1:0]  cfg_width  = WIDTH_LIMIT;
   logic [HEIGHT_W-1:0] cfg_height = HEIGHT_LIMIT;
   logic [DEPTH_W-1:0]  cfg_depth  = DEPTH_LIMIT;
   logic [CLIMB_W-1:0]  cfg_climb  = 5'd2;

   // Voxels already loaded by the stimulus, and the grid in use for it.
   bit [WORD_W-1:0] gen_written [MAX_DEPTH][MAX_WIDTH];
   int              gen_w, gen_h, gen_d;

   int   src_idle_pct  = 0;
   int   rsp_stall_pct = 0;
   int   mismatch_count = 0;
   bit   pressure_go = 1'b0;
   logic rsp_hold;

   always #1 clock = ~clock;

   function automatic int clamp_dim(input int v, input int lim);
      return (v > lim) ? lim : v;
   endfunction

   function automatic void predict_cost(input voxel_beat_type b);
      int              w, h, d, yi, ci, lo, hi, nx, nz, total;
      logic [WORD_W-1:0] window;
      bit              in_grid;
      cost_result_type r;
      w = clamp_dim(int'(cfg_width), MAX_WIDTH);
      h = clamp_dim(int'(cfg_height), MAX_HEIGHT);
      d = clamp_dim(int'(cfg_depth), MAX_DEPTH);
      in_grid = (int'(b.x) < w) && (int'(b.y) < h) && (int'(b.z) < d);
      if (b.func == FUNC_WRITE) begin
         if (in_grid)
            column_bits[b.z][b.x][b.y] = b.walkable;
         return;
      end
      r.cost = '0;
      r.coord_error = !in_grid;
      if (in_grid && column_bits[b.z][b.x][b.y]) begin
         // Support window runs from climb+2 below to climb above, inside the grid.
         yi = int'(b.y);
         ci = int'(cfg_climb);
         lo = (yi >= ci + 2) ? yi - ci - 2 : 0;
         hi = (yi + ci > h - 1) ? h - 1 : yi + ci;
         for (int k = 0; k < WORD_W; k++)
            window[k] = (k >= lo) && (k <= hi);
         total = 1;
         for (int dz = -1; dz <= 1; dz++) begin
            for (int dx = -1; dx <= 1; dx++) begin
               nx = int'(b.x) + dx;
               nz = int'(b.z) + dz;
               if (dx == 0 && dz == 0)
                  continue;
               if (nx < 0 || nx >= w || nz < 0 || nz >= d)
                  total += int'(COST_OUTSIDE);
               else if ((column_bits[nz][nx] & window) == '0)
                  total += int'(COST_CLIFF);
            end
         end
         if (total > int'(COST_LIMIT))
            total = int'(COST_LIMIT);
         r.cost = total[COST_W-1:0];
      end
      cost_expect_q.push_back(r);
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatch_count < PRINT_LIMIT)
         $display("%0t ns: response mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic push_beat(input logic func, input int x, input int y, input int z,
                            input logic walk);
      voxel_beat_type b;
      b.func = func;
      b.x = x[X_W-1:0];
      b.y = y[Y_W-1:0];
      b.z = z[Z_W-1:0];
      b.walkable = walk;
      if (func == FUNC_WRITE && x < gen_w && y < gen_h && z < gen_d)
         gen_written[z][x][y] = 1'b1;
      beat_pending_q.push_back(b);
   endtask

   function automatic int pick_coord(input int dim, input int full_max);
      if (dim == 0 || $urandom_range(99) < WIDE_PCT)
         return $urandom_range(full_max);
      return $urandom_range(dim - 1);
   endfunction

   task automatic add_random_beats(input int count);
      logic func;
      for (int i = 0; i < count; i++) begin
         func = ($urandom_range(99) < QUERY_PCT) ? FUNC_QUERY : FUNC_WRITE;
         push_beat(func, pick_coord(gen_w, (1 << X_W) - 1), pick_coord(gen_h, (1 << Y_W) - 1),
                   pick_coord(gen_d, (1 << Z_W) - 1), 1'($urandom_range(1)));
      end
   endtask

   // Hold until every beat is sent and answered, then let trailing writes finish.
   task automatic wait_quiet();
      while (beat_pending_q.size() != 0 || req_ch.valid || cost_expect_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic start_phase(input logic [CSR_DATA_W-1:0] w, input logic [CSR_DATA_W-1:0] h,
                              input logic [CSR_DATA_W-1:0] d, input logic [CSR_DATA_W-1:0] c,
                              input int density, input int src_pct, input int rsp_pct);
      wait_quiet();
      src_idle_pct = src_pct;
      rsp_stall_pct = rsp_pct;
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= CSR_GRID_WIDTH;
      csr_write_data <= w;
      @(posedge clock);
      csr_index      <= CSR_GRID_HEIGHT;
      csr_write_data <= h;
      @(posedge clock);
      csr_index      <= CSR_GRID_DEPTH;
      csr_write_data <= d;
      @(posedge clock);
      csr_index      <= CSR_MAX_CLIMB;
      csr_write_data <= c;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      cfg_width  = w[WIDTH_W-1:0];
      cfg_height = h[HEIGHT_W-1:0];
      cfg_depth  = d[DEPTH_W-1:0];
      cfg_climb  = c[CLIMB_W-1:0];
      gen_w = clamp_dim(int'(cfg_width), MAX_WIDTH);
      gen_h = clamp_dim(int'(cfg_height), MAX_HEIGHT);
      gen_d = clamp_dim(int'(cfg_depth), MAX_DEPTH);
      // Load every voxel of the grid that was never written, before any query.
      for (int z = 0; z < gen_d; z++)
         for (int x = 0; x < gen_w; x++)
            for (int y = 0; y < gen_h; y++)
               if (!gen_written[z][x][y])
                  push_beat(FUNC_WRITE, x, y, z, $urandom_range(99) < density);
   endtask

   // Request driver: hold a beat until accepted, predict it on acceptance.
   always @(posedge clock) begin
      voxel_beat_type beat;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            predict_cost(voxel_beat_type'({req_ch.func, req_ch.pos_x, req_ch.pos_y,
                                           req_ch.pos_z, req_ch.walkable}));
         if (!req_ch.valid || req_ch.ready) begin
            if (beat_pending_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
               beat = beat_pending_q.pop_front();
               req_ch.func     <= beat.func;
               req_ch.pos_x    <= beat.x;
               req_ch.pos_y    <= beat.y;
               req_ch.pos_z    <= beat.z;
               req_ch.walkable <= beat.walkable;
               req_ch.valid    <= 1'b1;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor.
   always @(posedge clock) begin
      cost_result_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (cost_expect_q.size() == 0) begin
               report_mismatch("response beat with no query outstanding");
            end else begin
               want = cost_expect_q.pop_front();
               if (rsp_ch.cost !== want.cost)
                  report_mismatch($sformatf("cost %0d, expected %0d", rsp_ch.cost, want.cost));
               if (rsp_ch.coord_error !== want.coord_error)
                  report_mismatch($sformatf("coord_error %0b, expected %0b",
                                            rsp_ch.coord_error, want.coord_error));
            end
         end
         rsp_ch.ready <= !rsp_hold && ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Long receiver hold-off so the block backs up into its request side.
   initial begin
      rsp_hold = 1'b0;
      wait (pressure_go);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      req_ch.valid    = 1'b0;
      req_ch.func     = FUNC_WRITE;
      req_ch.pos_x    = '0;
      req_ch.pos_y    = '0;
      req_ch.pos_z    = '0;
      req_ch.walkable = 1'b0;
      rsp_ch.ready    = 1'b0;
      csr_write_en    = 1'b0;
      csr_index       = CSR_GRID_WIDTH;
      csr_write_data  = '0;
      gen_w = 0;
      gen_h = 0;
      gen_d = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty 4x6x4 grid, climb 1, then hand-placed voxels.
      start_phase(7'd4, 7'd6, 7'd4, 7'd1, 0, IDLE_MIXED, IDLE_MIXED);
      push_beat(FUNC_WRITE, 1, 5, 1, 1'b1);
      push_beat(FUNC_QUERY, 1, 5, 1, 1'b0);   // every neighbor a cliff
      push_beat(FUNC_WRITE, 0, 2, 1, 1'b1);
      push_beat(FUNC_QUERY, 1, 5, 1, 1'b0);   // support at the bottom of the window
      push_beat(FUNC_WRITE, 2, 1, 2, 1'b1);
      push_beat(FUNC_QUERY, 1, 5, 1, 1'b0);   // just below the window
      push_beat(FUNC_WRITE, 1, 3, 2, 1'b1);
      push_beat(FUNC_QUERY, 1, 3, 2, 1'b0);
      push_beat(FUNC_QUERY, 0, 2, 1, 1'b1);   // grid edge; walkable ignored on a query
      push_beat(FUNC_WRITE, 3, 5, 3, 1'b1);
      push_beat(FUNC_QUERY, 3, 5, 3, 1'b0);   // far corner
      push_beat(FUNC_QUERY, 0, 0, 0, 1'b0);   // unwalkable voxel
      push_beat(FUNC_QUERY, 63, 31, 63, 1'b1);
      push_beat(FUNC_QUERY, 4, 0, 0, 1'b0);
      push_beat(FUNC_QUERY, 0, 6, 0, 1'b0);
      push_beat(FUNC_QUERY, 0, 0, 4, 1'b0);
      push_beat(FUNC_WRITE, 63, 31, 63, 1'b1); // outside the grid: dropped
      push_beat(FUNC_WRITE, 4, 0, 0, 1'b1);
      push_beat(FUNC_WRITE, 1, 5, 1, 1'b0);
      push_beat(FUNC_QUERY, 1, 5, 1, 1'b0);

      start_phase(7'd5, 7'd8, 7'd5, 7'd2, 50, IDLE_NONE, IDLE_NONE);
      add_random_beats(150);
      start_phase(7'd3, 7'd4, 7'd7, 7'd0, 30, IDLE_HEAVY, IDLE_NONE);
      add_random_beats(100);
      start_phase(7'd127, 7'd1, 7'd1, 7'd31, 60, IDLE_NONE, IDLE_HEAVY);
      add_random_beats(100);
      // Zero width: every query is out of range and every write dropped.
      start_phase(7'd0, 7'd32, 7'd64, 7'd5, 50, IDLE_MIXED, IDLE_MIXED);
      add_random_beats(60);
      // Upper data bits beyond the register width are dropped.
      start_phase(7'd1, 7'd127, 7'd3, 7'd127, 40, IDLE_HEAVY, IDLE_NONE);
      add_random_beats(60);
      start_phase(7'd64, 7'd2, 7'd2, 7'd3, 50, IDLE_NONE, IDLE_NONE);
      add_random_beats(60);
      start_phase(7'd6, 7'd8, 7'd6, 7'd4, 50, IDLE_NONE, IDLE_NONE);
      while (beat_pending_q.size() != 0)
         @(posedge clock);
      pressure_go = 1'b1;
      add_random_beats(200);
      start_phase(7'd6, 7'd5, 7'd6, 7'd1, 70, IDLE_NONE, IDLE_HEAVY);
      add_random_beats(140);
      start_phase(7'd1, 7'd1, 7'd1, 7'd0, 50, IDLE_MIXED, IDLE_MIXED);
      add_random_beats(50);

      wait_quiet();
      if (mismatch_count == 0 && cost_expect_q.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

[filelist.f]
sv/vcc_pkg.sv
sv/vcc_ifs.sv
sv/vcc_column_mem.sv
sv/voxel_cliff_cost.sv
sv/vcc_checker.sv
test/voxel_cliff_cost_tb.sv
